// ----- hw/rtl/wse_pkg.sv -----
// Package for the WebSocket client frame encoder.
// Holds the beat payload types, the item mode codes and the header constants.
// No dependencies; every other RTL file of the block imports it.
package wse_pkg;

    typedef enum logic {
        MODE_HEADER  = 1'b0,
        MODE_PAYLOAD = 1'b1
    } wse_mode_t;

    typedef struct packed {
        wse_mode_t   mode;
        logic [3:0]  opcode;
        logic [62:0] payload_length;
        logic [31:0] mask_key;
        logic [7:0]  payload_byte;
    } wse_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } wse_out_t;

    // One formatted byte of a run, with its end-of-run flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wse_fmt_t;

    // Controls for the key and byte index registers.
    typedef struct packed {
        logic load;
        logic step;
    } wse_key_ctl_t;

    localparam logic [7:0] FIN_BIT    = 8'h80;
    localparam logic [7:0] MASK_BIT   = 8'h80;
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    // Byte positions where the mask key starts, per length form.
    localparam logic [3:0] KEY_POS_LEN7  = 4'd2;
    localparam logic [3:0] KEY_POS_LEN16 = 4'd4;
    localparam logic [3:0] KEY_POS_LEN64 = 4'd10;
    localparam logic [3:0] LAST_POS_MAX  = 4'd13;

endpackage

// ----- hw/rtl/wse_in_if.sv -----
// Input channel of the frame encoder: valid, ready and one input item.
// Depends on wse_pkg for the item type.
interface wse_in_if;
    import wse_pkg::*;

    logic    valid;
    logic    ready;
    wse_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wse_out_if.sv -----
// Output channel of the frame encoder: valid, ready and one encoded byte.
// Depends on wse_pkg for the beat type.
interface wse_out_if;
    import wse_pkg::*;

    logic     valid;
    logic     ready;
    wse_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/websocket_client_frame_encoder.sv -----
// Top level of the WebSocket client frame encoder (client masking).
// Depends on wse_pkg, wse_in_if, wse_out_if, wse_hdr_fmt and wse_key_unit.
//
//   Channel | Dir | Beat contents
//   --------+-----+-----------------------------------------------------------
//   req     | in  | mode, opcode, payload_length, mask_key, payload_byte
//   rsp     | out | out_byte, last_of_run
//
// A payload item gives one beat; payload items stream at one per cycle while
// rsp does not stall. A header item gives 6, 8 or 14 beats and holds the item
// register until its last byte goes out. Results pass from the item register
// through the output register. Reset clears the key to zero and the byte
// index to zero. A stall on rsp holds the output register, and the item
// register fills behind it so req stays ready until both are occupied.
module websocket_client_frame_encoder (
    input  logic    clk,
    input  logic    rst_n,
    wse_in_if.sink  req,
    wse_out_if.source rsp
);
    import wse_pkg::*;

    // The item register holds the item whose bytes are being produced.
    logic         item_valid_reg;
    logic         item_valid_next;
    wse_in_t      item_reg;
    wse_in_t      item_next;
    // Byte position within the current header run.
    logic [3:0]   cnt_reg;
    logic [3:0]   cnt_next;

    // The output register carries one beat toward rsp.
    logic         out_valid_reg;
    logic         out_valid_next;
    wse_out_t     out_reg;
    wse_out_t     out_next;

    wse_fmt_t     hdr_fmt;
    wse_key_ctl_t key_ctl;
    logic [7:0]   masked_byte;
    logic         emit;
    logic         cur_last;
    logic [7:0]   cur_byte;
    logic         item_done;
    logic         req_fire;

    wse_hdr_fmt u_hdr_fmt (
        .item (item_reg),
        .cnt  (cnt_reg),
        .fmt  (hdr_fmt)
    );

    // The key is latched on the first header byte, so payload bytes that
    // follow the header in order always see the new key.
    assign key_ctl.load = emit && (item_reg.mode == MODE_HEADER) && (cnt_reg == 4'd0);
    assign key_ctl.step = emit && (item_reg.mode == MODE_PAYLOAD);

    wse_key_unit u_key_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (key_ctl),
        .new_key     (item_reg.mask_key),
        .raw_byte    (item_reg.payload_byte),
        .masked_byte (masked_byte)
    );

    // A byte moves into the output register whenever that register is free
    // or is being drained in this same cycle.
    assign emit      = item_valid_reg && (!out_valid_reg || rsp.ready);
    assign cur_last  = (item_reg.mode == MODE_PAYLOAD) ? 1'b1 : hdr_fmt.last;
    assign cur_byte  = (item_reg.mode == MODE_PAYLOAD) ? masked_byte : hdr_fmt.data;
    assign item_done = emit && cur_last;

    assign req.ready = !item_valid_reg || item_done;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        cnt_next        = cnt_reg;
        if (req_fire)
        begin
            item_valid_next = 1'b1;
            item_next       = req.data;
            cnt_next        = 4'd0;
        end
        else if (item_done)
        begin
            item_valid_next = 1'b0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = cur_byte;
            out_next.last_of_run = cur_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // A header run only ends at one of its three legal lengths.
    a_hdr_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && (item_reg.mode == MODE_HEADER) && hdr_fmt.last) |->
        (cnt_reg == 4'd5 || cnt_reg == 4'd7 || cnt_reg == LAST_POS_MAX))
        else $error("header run ends at an illegal byte position");

    // The byte counter never runs past the longest header.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (cnt_reg <= LAST_POS_MAX))
        else $error("header byte counter out of range");

    // A payload item is always finished by its first emitted byte.
    a_payload_single: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && (item_reg.mode == MODE_PAYLOAD)) |-> (cnt_reg == 4'd0))
        else $error("payload item held for more than one byte");

    // When the output is stalled, no new byte may be emitted over it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !emit)
        else $error("output register overwritten while stalled");

endmodule

// ----- hw/rtl/wse_hdr_fmt.sv -----
// Header byte formatter: picks byte number cnt of a frame header.
// Depends on wse_pkg for the item and formatter types.
module wse_hdr_fmt (
    input  wse_pkg::wse_in_t  item,
    input  logic [3:0]        cnt,
    output wse_pkg::wse_fmt_t fmt
);
    import wse_pkg::*;

    logic        len_small;
    logic        len_mid;
    logic [3:0]  key_pos;
    logic [3:0]  key_off;
    logic [3:0]  len_off;
    logic [63:0] len64;
    logic [7:0]  key_byte;
    logic [7:0]  len_byte;
    logic [7:0]  len_code_byte;

    assign len_small = (item.payload_length < 63'(LEN16_CODE));
    assign len_mid   = (item.payload_length[62:16] == '0);
    assign len64     = {1'b0, item.payload_length};

    always_comb
    begin
        if (len_small)
        begin
            key_pos       = KEY_POS_LEN7;
            len_code_byte = MASK_BIT | {1'b0, item.payload_length[6:0]};
        end
        else if (len_mid)
        begin
            key_pos       = KEY_POS_LEN16;
            len_code_byte = MASK_BIT | {1'b0, LEN16_CODE};
        end
        else
        begin
            key_pos       = KEY_POS_LEN64;
            len_code_byte = MASK_BIT | {1'b0, LEN64_CODE};
        end
    end

    assign key_off = cnt - key_pos;
    assign len_off = cnt - KEY_POS_LEN7;

    always_comb
    begin
        case (key_off[1:0])
            2'd0:    key_byte = item.mask_key[31:24];
            2'd1:    key_byte = item.mask_key[23:16];
            2'd2:    key_byte = item.mask_key[15:8];
            default: key_byte = item.mask_key[7:0];
        endcase
    end

    // The 16-bit form is the last two bytes of the 64-bit form.
    always_comb
    begin
        if (len_mid)
        begin
            len_byte = len_off[0] ? len64[7:0] : len64[15:8];
        end
        else
        begin
            case (len_off[2:0])
                3'd0:    len_byte = len64[63:56];
                3'd1:    len_byte = len64[55:48];
                3'd2:    len_byte = len64[47:40];
                3'd3:    len_byte = len64[39:32];
                3'd4:    len_byte = len64[31:24];
                3'd5:    len_byte = len64[23:16];
                3'd6:    len_byte = len64[15:8];
                default: len_byte = len64[7:0];
            endcase
        end
    end

    always_comb
    begin
        if (cnt == 4'd0)
        begin
            fmt.data = FIN_BIT | {4'd0, item.opcode};
        end
        else if (cnt == 4'd1)
        begin
            fmt.data = len_code_byte;
        end
        else if (cnt >= key_pos)
        begin
            fmt.data = key_byte;
        end
        else
        begin
            fmt.data = len_byte;
        end
        fmt.last = (cnt == key_pos + 4'd3);
    end

endmodule

// ----- hw/rtl/wse_key_unit.sv -----
// Mask key store and payload byte index, plus the payload XOR.
// Depends on wse_pkg for the control struct.
module wse_key_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wse_pkg::wse_key_ctl_t ctl,
    input  logic [31:0]           new_key,
    input  logic [7:0]            raw_byte,
    output logic [7:0]            masked_byte
);
    import wse_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [7:0]  key_byte;

    always_comb
    begin
        key_next = key_reg;
        idx_next = idx_reg;
        if (ctl.load)
        begin
            key_next = new_key;
            idx_next = 2'd0;
        end
        else if (ctl.step)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign masked_byte = raw_byte ^ key_byte;

endmodule

// ----- test/wse_frame_checker.sv -----
// Scoreboard for the WebSocket client frame encoder: watches req and rsp,
// predicts every output beat and compares it with what the encoder sends.
// Depends on wse_pkg, wse_in_if and wse_out_if.
module wse_frame_checker (
    input  logic clk,
    input  logic rst_n,
    wse_in_if    req,
    wse_out_if   rsp,
    output int   error_count,
    output int   beats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wse_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [31:0] mask_key_q;
    logic [1:0]  key_index_q;
    wse_out_t    expected_beats[$];

    // Builds the beats that one accepted item must produce and updates the
    // shadow key and byte index.
    function automatic void encode_item(wse_in_t item);
        logic [7:0]  frame[$];
        logic [63:0] len64;
        wse_out_t    beat;
        len64 = {1'b0, item.payload_length};
        if (item.mode == MODE_PAYLOAD)
        begin
            beat.out_byte    = item.payload_byte
                             ^ mask_key_q[(3 - int'(key_index_q)) * 8 +: 8];
            beat.last_of_run = 1'b1;
            expected_beats.push_back(beat);
            key_index_q = key_index_q + 2'd1;
        end
        else
        begin
            frame.push_back(FIN_BIT | {4'h0, item.opcode});
            if (item.payload_length < 63'd126)
            begin
                frame.push_back(MASK_BIT | {1'b0, item.payload_length[6:0]});
            end
            else if (item.payload_length < 63'd65536)
            begin
                frame.push_back(MASK_BIT | {1'b0, LEN16_CODE});
                frame.push_back(len64[15:8]);
                frame.push_back(len64[7:0]);
            end
            else
            begin
                frame.push_back(MASK_BIT | {1'b0, LEN64_CODE});
                for (int k = 7; k >= 0; k--)
                begin
                    frame.push_back(len64[k * 8 +: 8]);
                end
            end
            for (int k = 3; k >= 0; k--)
            begin
                frame.push_back(item.mask_key[k * 8 +: 8]);
            end
            mask_key_q  = item.mask_key;
            key_index_q = '0;
            foreach (frame[i])
            begin
                beat.out_byte    = frame[i];
                beat.last_of_run = (i == frame.size() - 1);
                expected_beats.push_back(beat);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wse_out_t want;
        if (!rst_n)
        begin
            mask_key_q  = '0;
            key_index_q = '0;
            expected_beats.delete();
            error_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                encode_item(req.data);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("unexpected beat: out_byte %02h last_of_run %0b",
                                 rsp.data.out_byte, rsp.data.last_of_run);
                    end
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (rsp.data.out_byte !== want.out_byte
                        || rsp.data.last_of_run !== want.last_of_run)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                                     want.out_byte, rsp.data.out_byte,
                                     want.last_of_run, rsp.data.last_of_run);
                        end
                    end
                end
            end
        end
        beats_pending = expected_beats.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the frame encoder testbench: clock, reset, stimulus on req, flow
// control on rsp and the final verdict.
// Depends on wse_pkg, wse_in_if, wse_out_if, wse_frame_checker and the encoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wse_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          RESET_CYCLES = 8;
    // The slowest correct run is about 500 items of up to 14 beats, each beat
    // held by a random receiver stall, plus sender gaps and one long hold. That
    // stays well below this limit, so the limit only catches a hung encoder.
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [62:0] LEN_MAX      = '1;

    logic clk;
    logic rst_n;

    wse_in_if  req ();
    wse_out_if rsp ();

    int error_count;
    int beats_pending;
    int cycle_count;
    int items_sent;

    // When set, neither side inserts idle cycles, so the encoder sees
    // back-to-back beats on both channels.
    bit no_gaps;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_request;

    websocket_client_frame_encoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    wse_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .error_count   (error_count),
        .beats_pending (beats_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Lengths are drawn from each header form, from the boundaries between
    // them, and from the full 63-bit range so that every bit toggles.
    function automatic logic [62:0] random_length();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return 63'($urandom_range(0, 125));
            1: return 63'($urandom_range(126, 65535));
            2: return wide[63:1];
            3: return 63'(wide >> $urandom_range(2, 62));
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return 63'd125;
                    1: return 63'd126;
                    2: return 63'd65535;
                    3: return 63'd65536;
                    4: return LEN_MAX;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Every field gets a random value, so the fields that the chosen mode
    // ignores always carry noise.
    function automatic wse_in_t random_fields();
        wse_in_t it;
        it.mode           = wse_mode_t'($urandom_range(0, 1));
        it.opcode         = 4'($urandom_range(0, 15));
        it.payload_length = random_length();
        it.mask_key       = $urandom;
        it.payload_byte   = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic wse_in_t header_item(logic [3:0] op, logic [62:0] len,
                                            logic [31:0] key);
        wse_in_t it;
        it                = random_fields();
        it.mode           = MODE_HEADER;
        it.opcode         = op;
        it.payload_length = len;
        it.mask_key       = key;
        return it;
    endfunction

    function automatic wse_in_t payload_item(logic [7:0] value);
        wse_in_t it;
        it              = random_fields();
        it.mode         = MODE_PAYLOAD;
        it.payload_byte = value;
        return it;
    endfunction

    // Offers one item after a random gap and returns at the falling edge that
    // follows its acceptance. Valid stays high between items unless a gap is
    // drawn, so gapless calls stream one item per cycle while req stays ready.
    task automatic send_item(input wse_in_t item);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            req.data  <= random_fields();
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= item;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    // Drops valid and waits until the checker holds no outstanding beat.
    task automatic wait_for_drain();
        req.valid <= 1'b0;
        while (beats_pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Random traffic. Most of it is well-formed frames: a header whose length
    // matches the number of payload bytes that follow. The rest is headers
    // with unrelated lengths and single items of either mode, which also
    // exercises back-to-back headers and payload runs of any length.
    task automatic run_traffic(int n_items);
        int          stop_at;
        int          run;
        logic [62:0] len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                run = $urandom_range(0, 12);
                len = ($urandom_range(0, 3) != 0) ? 63'(run) : random_length();
                send_item(header_item(4'($urandom_range(0, 15)), len, $urandom));
                repeat (run)
                begin
                    send_item(payload_item(8'($urandom_range(0, 255))));
                end
            end
            else
            begin
                send_item(random_fields());
            end
        end
    endtask

    // Receiver: before every beat it draws a random stall, and on request it
    // holds ready low for a long stretch so that the output register and the
    // item register both fill and req stalls.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        req.valid = 1'b0;
        req.data  = '0;
        rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Payload bytes before any header use the reset key of zero and
        // must pass through unchanged.
        send_item(payload_item(8'h00));
        send_item(payload_item(8'hFF));

        // Shortest header with all-zero fields, then the largest 7-bit length
        // with the highest opcode and an all-ones key. Five payload bytes
        // follow so the byte index wraps around.
        send_item(header_item(4'h0, 63'd0, 32'h0000_0000));
        send_item(header_item(4'hF, 63'd125, 32'hFFFF_FFFF));
        send_item(payload_item(8'h00));
        send_item(payload_item(8'hFF));
        send_item(payload_item(8'h5A));
        send_item(payload_item(8'hA5));
        send_item(payload_item(8'h3C));

        // Both edges of the 16-bit length form. A new header must clear the
        // byte index, so the payload byte after it uses key byte zero.
        send_item(header_item(4'h1, 63'd126, 32'h1234_5678));
        send_item(payload_item(8'h00));
        send_item(header_item(4'h2, 63'd65535, 32'h8000_0001));

        // The 64-bit length form: its lower edge, the largest 63-bit length,
        // a length just past 32 bits and one with only the top bit set.
        send_item(header_item(4'h8, 63'd65536, 32'hDEAD_BEEF));
        send_item(payload_item(8'hFF));
        send_item(payload_item(8'hFF));
        send_item(header_item(4'h9, LEN_MAX, 32'hA5A5_5A5A));
        send_item(header_item(4'hA, 63'h1_0000_0000, 32'h0000_00FF));
        send_item(payload_item(8'h81));
        send_item(payload_item(8'h7E));
        send_item(payload_item(8'hC3));
        send_item(header_item(4'h7, 63'h4000_0000_0000_0000, 32'h0000_0000));
        send_item(payload_item(8'h96));

        // Random traffic with gaps on both sides.
        run_traffic(150);

        // A stretch without any idle cycles.
        no_gaps = 1'b1;
        run_traffic(60);

        // The receiver holds off while the sender keeps offering items, so
        // the encoder fills up and must stall req.
        hold_request = 1'b1;
        run_traffic(50);
        no_gaps = 1'b0;

        // The sender pauses until every outstanding beat has come out, then
        // resumes from an empty encoder.
        wait_for_drain();
        run_traffic(220);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && beats_pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
